>>> hdl/sfcd_pkg.sv
// Shared types and constants for the sensor frame checker with duplicate filter.
// Holds the frame layout, status codes, history sizing and the controller-to-datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfcd_pkg;

   // Frame layout.
   localparam int FRAME_LEN     = 15;
   localparam int SUM_FIRST     = 1;
   localparam int SUM_LAST      = 12;
   localparam int KEY_BYTES     = 12;
   localparam int KEY_W         = KEY_BYTES * 8;
   localparam int LINE_W        = 16;
   localparam int CNT_W         = 4;

   localparam logic [7:0] START_MARK = 8'h0E;
   localparam logic [7:0] STOP_MARK  = 8'hFE;
   localparam logic [7:0] LEN_CODE   = 8'd15;

   // History ring sizing.
   localparam int HIST_DEPTH = 16;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);
   localparam int HIST_W     = KEY_W + LINE_W;

   // Result status codes.
   localparam logic [1:0] ST_VALID = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;
   localparam logic [1:0] ST_DUP   = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;          // Store the accepted input beat.
      logic eval;          // Latch the frame check verdict.
      logic search_start;  // Read history entry 0.
      logic search_next;   // Read the following history entry.
      logic mark_dup;      // Record a history hit.
      logic hist_write;    // Store the frame in the history ring.
      logic load;          // Move the result into the output register.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_short;
      logic frame_bad;
      logic hist_empty;
      logic hit;
      logic search_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> hdl/sfcd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/sfcd_dp.sv
// Datapath: frame byte capture, running checksum, frame checks, history ring
// search and write, line counter and the result output register.
// Depends on sfcd_pkg and sfcd_ram.
`timescale 1ns / 1ps
`default_nettype none

module sfcd_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sfcd_pkg::cmd_type    cmd,
   output sfcd_pkg::stat_type        stat,
   input  wire logic [7:0]           req_data_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [15:0]               rsp_line_index,
   output logic [15:0]               rsp_match_line,
   output logic [7:0]                rsp_sensor_id,
   output logic [7:0]                rsp_location,
   output logic [31:0]               rsp_timestamp,
   output logic [31:0]               rsp_lux_bits,
   output logic [7:0]                rsp_condition
);

   localparam int AW = sfcd_pkg::HIST_AW;
   localparam int CW = sfcd_pkg::HIST_CW;
   localparam int KW = sfcd_pkg::KEY_W;
   localparam int LW = sfcd_pkg::LINE_W;

   logic [7:0]                 frame_ff [sfcd_pkg::FRAME_LEN];
   logic [sfcd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [LW-1:0]              line_ff, line_in;
   logic [CW-1:0]              fill_ff, fill_in;
   logic [AW-1:0]              next_ff, next_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [1:0]                 verdict_ff, verdict_in;
   logic [LW-1:0]              match_ff, match_in;
   logic                       out_valid_ff, out_valid_in;
   logic [1:0]                 o_status_ff;
   logic [LW-1:0]              o_line_ff, o_match_ff;
   logic [7:0]                 o_sensor_ff, o_loc_ff, o_cond_ff;
   logic [31:0]                o_time_ff, o_lux_ff;

   logic                       frame_full;
   logic [KW-1:0]              key;
   logic [sfcd_pkg::HIST_W-1:0] ram_rd, ram_wr;
   logic                       good;

   // Running sum and byte count as beats arrive; the count saturates at a full frame.
   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.take && !frame_full) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '0) begin
            sum_in = '0;
         end else if (cnt_ff <= sfcd_pkg::CNT_W'(sfcd_pkg::SUM_LAST)) begin
            sum_in = sum_ff + req_data_byte;
         end
      end
   end

   assign frame_full = (cnt_ff == sfcd_pkg::CNT_W'(sfcd_pkg::FRAME_LEN));

   // Frame bytes are written at the byte count and read at fixed places.
   always_ff @(posedge clock) begin
      if (cmd.take && !frame_full) begin
         frame_ff[cnt_ff] <= req_data_byte;
      end
   end

   // Duplicate key is bytes 1 to 12, byte 1 in the top bits.
   always_comb begin
      key = '0;
      for (int k = 0; k < sfcd_pkg::KEY_BYTES; k++) begin
         key[KW-1-8*k -: 8] = frame_ff[k + 1];
      end
   end

   // Frame checks: markers, length code and checksum over bytes 1 to 12.
   always_comb begin
      good = (frame_ff[0] == sfcd_pkg::START_MARK) &&
             (frame_ff[14] == sfcd_pkg::STOP_MARK) &&
             (frame_ff[1] == sfcd_pkg::LEN_CODE) &&
             (8'(sum_ff + frame_ff[13]) == 8'd0);
   end

   // History ring storage.
   assign ram_wr = {key, line_ff};

   sfcd_ram #(
      .WIDTH (sfcd_pkg::HIST_W),
      .DEPTH (sfcd_pkg::HIST_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.hist_write),
      .wr_addr (next_ff),
      .wr_data (ram_wr),
      .rd_addr (idx_in),
      .rd_data (ram_rd)
   );

   // Search index drives the RAM read address from its next value, ahead of the compare on the registered read data.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.search_start) begin
         idx_in = '0;
      end else if (cmd.search_next) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Ring pointer and fill level.
   always_comb begin
      next_in = next_ff;
      fill_in = fill_ff;
      if (cmd.hist_write) begin
         if (next_ff == AW'(sfcd_pkg::HIST_DEPTH - 1)) begin
            next_in = '0;
         end else begin
            next_in = next_ff + 1'b1;
         end
         if (fill_ff != CW'(sfcd_pkg::HIST_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // Verdict and matching line for the current frame.
   always_comb begin
      verdict_in = verdict_ff;
      match_in   = match_ff;
      if (cmd.eval) begin
         match_in = '0;
         if (!frame_full) begin
            verdict_in = sfcd_pkg::ST_SHORT;
         end else if (!good) begin
            verdict_in = sfcd_pkg::ST_BAD;
         end else begin
            verdict_in = sfcd_pkg::ST_VALID;
         end
      end else if (cmd.mark_dup) begin
         verdict_in = sfcd_pkg::ST_DUP;
         match_in   = ram_rd[LW-1:0];
      end
   end

   // Line counter saturates at its maximum.
   always_comb begin
      line_in = line_ff;
      if (cmd.load && line_ff != '1) begin
         line_in = line_ff + 1'b1;
      end
   end

   // Output register handshake.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         line_ff      <= '0;
         fill_ff      <= '0;
         next_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         line_ff      <= line_in;
         fill_ff      <= fill_in;
         next_ff      <= next_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      idx_ff     <= idx_in;
      verdict_ff <= verdict_in;
      match_ff   <= match_in;
   end

   // Result register; decoded fields are zero unless the frame is new and valid.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         o_status_ff <= verdict_ff;
         o_line_ff   <= line_ff;
         o_match_ff  <= match_ff;
         if (verdict_ff == sfcd_pkg::ST_VALID) begin
            o_sensor_ff <= frame_ff[2];
            o_loc_ff    <= frame_ff[3];
            o_time_ff   <= {frame_ff[4], frame_ff[5], frame_ff[6], frame_ff[7]};
            o_lux_ff    <= {frame_ff[8], frame_ff[9], frame_ff[10], frame_ff[11]};
            o_cond_ff   <= frame_ff[12];
         end else begin
            o_sensor_ff <= '0;
            o_loc_ff    <= '0;
            o_time_ff   <= '0;
            o_lux_ff    <= '0;
            o_cond_ff   <= '0;
         end
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.frame_short = !frame_full;
      stat.frame_bad   = !good;
      stat.hist_empty  = (fill_ff == '0);
      stat.hit         = (ram_rd[sfcd_pkg::HIST_W-1:LW] == key);
      stat.search_last = ((CW'(idx_ff) + 1'b1) == fill_ff);
      stat.out_free    = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = o_status_ff;
   assign rsp_line_index = o_line_ff;
   assign rsp_match_line = o_match_ff;
   assign rsp_sensor_id  = o_sensor_ff;
   assign rsp_location   = o_loc_ff;
   assign rsp_timestamp  = o_time_ff;
   assign rsp_lux_bits   = o_lux_ff;
   assign rsp_condition  = o_cond_ff;

endmodule

`default_nettype wire

>>> hdl/sfcd_ctrl.sv
// Controller: sequences byte collection, frame check, history search and write,
// and hand-off of each line's result to the output register.
// Depends on sfcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfcd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_line_end,
   output logic                     req_ready,
   input  wire sfcd_pkg::stat_type  stat,
   output sfcd_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      S_COLLECT,
      S_EVAL,
      S_SEARCH,
      S_WRITE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_COLLECT: begin
            cmd.take = req_valid;
            if (req_valid && req_line_end) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.frame_short || stat.frame_bad) begin
               state_in = S_DONE;
            end else if (stat.hist_empty) begin
               state_in = S_WRITE;
            end else begin
               cmd.search_start = 1'b1;
               state_in         = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (stat.hit) begin
               cmd.mark_dup = 1'b1;
               state_in     = S_DONE;
            end else if (stat.search_last) begin
               state_in = S_WRITE;
            end else begin
               cmd.search_next = 1'b1;
            end
         end
         S_WRITE: begin
            cmd.hist_write = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_COLLECT;
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_COLLECT);

endmodule

`default_nettype wire

>>> hdl/sensor_frame_checker_dedup.sv
// Sensor frame checker with duplicate filter, top level.
// Joins the controller (sfcd_ctrl) and the datapath (sfcd_dp); depends on sfcd_pkg.
//
// Usage:
//   The req_ channel carries one raw byte per beat; req_line_end marks the last
//   byte of a line. Bytes are taken one per cycle while a line is being collected.
//   After the last byte of a line the block stops taking beats while it checks
//   the frame and searches the history ring, then returns one result beat on the
//   rsp_ channel per line: status, line index, matching earlier line and the
//   decoded sensor fields.
//   From the last byte to the result register the line passes the frame check;
//   a well-formed frame then reads history entries up to and including a match
//   (1 to 16 entries) or all entries held (0 to 16; none when the history is
//   empty), a new frame is written into the ring, and the result is loaded.
//   The history RAM gives one entry per cycle, which sets the search time.
//   While a result waits in the output register the next line is already
//   collected; if the receiver stalls, the block holds the following result
//   and stops taking bytes until the register is free.
//   Reset clears the byte count, line counter, history fill level and the
//   output valid; history contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_checker_dedup (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_line_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_line_index,
   output logic [15:0]      rsp_match_line,
   output logic [7:0]       rsp_sensor_id,
   output logic [7:0]       rsp_location,
   output logic [31:0]      rsp_timestamp,
   output logic [31:0]      rsp_lux_bits,
   output logic [7:0]       rsp_condition
);

   sfcd_pkg::cmd_type  cmd;
   sfcd_pkg::stat_type stat;

   // Sequencer.
   sfcd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_line_end (req_line_end),
      .req_ready    (req_ready),
      .stat         (stat),
      .cmd          (cmd)
   );

   // Frame storage, checks, history and result register.
   sfcd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_line_index (rsp_line_index),
      .rsp_match_line (rsp_match_line),
      .rsp_sensor_id  (rsp_sensor_id),
      .rsp_location   (rsp_location),
      .rsp_timestamp  (rsp_timestamp),
      .rsp_lux_bits   (rsp_lux_bits),
      .rsp_condition  (rsp_condition)
   );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for sensor_frame_checker_dedup: random and directed byte lines
// on the req_ channel, results on the rsp_ channel checked against a scoreboard predictor.
// Depends on sfcd_pkg and the sensor_frame_checker_dedup RTL.
`timescale 1ns / 1ps

module testbench;
   import sfcd_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int RECENT_MAX  = 24;
   localparam int LONG_HOLD   = 400;

   // One result beat, laid out in the order of the rsp_ ports.
   typedef struct packed {
      logic [1:0]        status;
      logic [LINE_W-1:0] line_index;
      logic [LINE_W-1:0] match_line;
      logic [7:0]        sensor_id;
      logic [7:0]        location;
      logic [31:0]       timestamp;
      logic [31:0]       lux_bits;
      logic [7:0]        condition;
   } frame_result_type;

   typedef enum {RX_OPEN, RX_BUSY, RX_SPARSE} rx_mode_type;

   // Predicts the verdict of every line and checks result beats in order.
   class frame_scoreboard;
      logic [7:0]        frame_buf[FRAME_LEN];
      int                byte_count;
      logic [LINE_W-1:0] line_count;
      logic [KEY_W-1:0]  hist_key[HIST_DEPTH];
      logic [LINE_W-1:0] hist_line[HIST_DEPTH];
      int                hist_fill;
      int                hist_next;
      frame_result_type  pending[$];
      int                errors;

      function new();
         byte_count = 0;
         line_count = '0;
         hist_fill  = 0;
         hist_next  = 0;
         errors     = 0;
      endfunction

      // Takes one accepted input beat; a line end queues the expected result.
      function void note_beat(logic [7:0] data, logic last);
         frame_result_type want;
         logic [KEY_W-1:0] key;
         logic [7:0]      sum;
         logic            hit;
         if (byte_count < FRAME_LEN) begin
            frame_buf[byte_count] = data;
            byte_count++;
         end
         if (!last) return;
         want = '0;
         want.line_index = line_count;
         sum = LEN_CODE;
         for (int k = SUM_FIRST + 1; k <= SUM_LAST; k++) sum = sum + frame_buf[k];
         if (byte_count < FRAME_LEN) begin
            want.status = ST_SHORT;
         end else if (frame_buf[0] != START_MARK || frame_buf[1] != LEN_CODE ||
                      frame_buf[FRAME_LEN-1] != STOP_MARK ||
                      frame_buf[SUM_LAST+1] != 8'(8'd0 - sum)) begin
            // A wrong length byte also changes the sum, but the frame fails either way.
            want.status = ST_BAD;
         end else begin
            key = '0;
            for (int k = SUM_FIRST; k <= SUM_LAST; k++) key = {key[KEY_W-9:0], frame_buf[k]};
            hit = 1'b0;
            for (int i = 0; i < hist_fill; i++) begin
               if (!hit && hist_key[i] == key) begin
                  hit = 1'b1;
                  want.match_line = hist_line[i];
               end
            end
            if (hit) begin
               want.status = ST_DUP;
            end else begin
               // New frame: store it over the oldest slot and decode it.
               hist_key[hist_next]  = key;
               hist_line[hist_next] = line_count;
               hist_next = (hist_next == HIST_DEPTH - 1) ? 0 : hist_next + 1;
               if (hist_fill < HIST_DEPTH) hist_fill++;
               want.status    = ST_VALID;
               want.sensor_id = frame_buf[2];
               want.location  = frame_buf[3];
               want.timestamp = {frame_buf[4], frame_buf[5], frame_buf[6], frame_buf[7]};
               want.lux_bits  = {frame_buf[8], frame_buf[9], frame_buf[10], frame_buf[11]};
               want.condition = frame_buf[12];
            end
         end
         pending.push_back(want);
         byte_count = 0;
         if (line_count != '1) line_count++;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("Field %s: expected %0h, got %0h.", name, want, got);
            errors++;
         end
      endfunction

      // Compares one accepted result beat with the oldest expected result.
      function void check_result(frame_result_type got);
         frame_result_type want;
         if (pending.size() == 0) begin
            $error("Result beat for line %0d arrived with no line pending.", got.line_index);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("line_index", 32'(want.line_index), 32'(got.line_index));
         compare_field("match_line", 32'(want.match_line), 32'(got.match_line));
         compare_field("sensor_id", 32'(want.sensor_id), 32'(got.sensor_id));
         compare_field("location", 32'(want.location), 32'(got.location));
         compare_field("timestamp", want.timestamp, got.timestamp);
         compare_field("lux_bits", want.lux_bits, got.lux_bits);
         compare_field("condition", 32'(want.condition), 32'(got.condition));
      endfunction
   endclass

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_line_end  = 1'b0;
   logic        rsp_ready     = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_line_index;
   logic [15:0] rsp_match_line;
   logic [7:0]  rsp_sensor_id;
   logic [7:0]  rsp_location;
   logic [31:0] rsp_timestamp;
   logic [31:0] rsp_lux_bits;
   logic [7:0]  rsp_condition;

   frame_scoreboard sb = new();

   // Stimulus state.
   logic [7:0]  line_buf[$];
   logic [87:0] recent_bodies[$];
   int          burst_left    = 0;
   int          bytes_sent    = 0;

   // Receiver control, written by the stimulus with a nonblocking assignment.
   bit          hold_request  = 1'b0;

   // Receiver state.
   rx_mode_type rx_mode       = RX_OPEN;
   int          rx_mode_left  = 0;
   int          hold_left     = 0;
   bit          hold_taken    = 1'b0;
   int          cycle_count   = 0;

   sensor_frame_checker_dedup uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_line_end   (req_line_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_line_index (rsp_line_index),
      .rsp_match_line (rsp_match_line),
      .rsp_sensor_id  (rsp_sensor_id),
      .rsp_location   (rsp_location),
      .rsp_timestamp  (rsp_timestamp),
      .rsp_lux_bits   (rsp_lux_bits),
      .rsp_condition  (rsp_condition)
   );

   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: checks each accepted result beat and picks the next ready value.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result({rsp_status, rsp_line_index, rsp_match_line, rsp_sensor_id,
                             rsp_location, rsp_timestamp, rsp_lux_bits, rsp_condition});
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request && !hold_taken) begin
            // One long stall so that the block fills up and blocks its input.
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      = rx_mode_type'($urandom_range(0, 2));
               rx_mode_left = $urandom_range(1, 40);
            end
            rx_mode_left--;
            case (rx_mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_BUSY:   rsp_ready <= ($urandom_range(0, 3) != 0);
               default:   rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offers one beat and waits until it is accepted; gaps come between bursts.
   task automatic offer(input logic [7:0] data, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 12);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_line_end  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_beat(data, last);
      bytes_sent++;
   endtask

   task automatic send_line();
      for (int k = 0; k < line_buf.size(); k++) offer(line_buf[k], k == line_buf.size() - 1);
   endtask

   // Drops req_valid and waits until every expected result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // Builds a well-formed frame around bytes 2..12 (body bits 87:80 are byte 2).
   task automatic make_frame(input logic [87:0] body);
      logic [7:0] sum;
      line_buf.delete();
      line_buf.push_back(START_MARK);
      line_buf.push_back(LEN_CODE);
      sum = LEN_CODE;
      for (int k = 0; k < 11; k++) begin
         line_buf.push_back(body[87 - 8*k -: 8]);
         sum = sum + body[87 - 8*k -: 8];
      end
      line_buf.push_back(8'd0 - sum);
      line_buf.push_back(STOP_MARK);
   endtask

   function automatic logic [87:0] fresh_body();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom(), 24'($urandom())};
      endcase
   endfunction

   task automatic remember(input logic [87:0] body);
      recent_bodies.push_back(body);
      if (recent_bodies.size() > RECENT_MAX) void'(recent_bodies.pop_front());
   endtask

   // One random line: mostly good frames and repeats, then broken and short lines.
   task automatic random_line();
      int          pick;
      int          n;
      int          pos;
      logic [87:0] body;
      pick = $urandom_range(0, 99);
      if (pick < 45 || (pick < 75 && recent_bodies.size() == 0)) begin
         body = fresh_body();
         remember(body);
         make_frame(body);
      end else if (pick < 70) begin
         // Repeat of a recent frame: a duplicate, or new if its slot was overwritten.
         make_frame(recent_bodies[$urandom_range(0, recent_bodies.size() - 1)]);
      end else if (pick < 75) begin
         // Near miss: one key bit differs from a recent frame.
         body = recent_bodies[$urandom_range(0, recent_bodies.size() - 1)] ^
                (88'd1 << $urandom_range(0, 87));
         remember(body);
         make_frame(body);
      end else if (pick < 85) begin
         // Broken frame: start, length, stop, checksum, or a byte under the checksum.
         make_frame(fresh_body());
         case ($urandom_range(0, 4))
            0:       pos = 0;
            1:       pos = 1;
            2:       pos = FRAME_LEN - 1;
            3:       pos = SUM_LAST + 1;
            default: pos = $urandom_range(2, SUM_LAST);
         endcase
         line_buf[pos] = line_buf[pos] ^ 8'($urandom_range(1, 255));
      end else if (pick < 95) begin
         n = $urandom_range(1, FRAME_LEN - 1);
         if ($urandom_range(0, 1) == 0) begin
            make_frame(fresh_body());
            while (line_buf.size() > n) void'(line_buf.pop_back());
         end else begin
            line_buf.delete();
            repeat (n) line_buf.push_back(8'($urandom()));
         end
      end else begin
         line_buf.delete();
         repeat (FRAME_LEN) line_buf.push_back(8'($urandom()));
         if ($urandom_range(0, 1) == 0) line_buf[0] = START_MARK;
      end
      // Trailing bytes past the fifteenth are dropped by the block.
      if (line_buf.size() == FRAME_LEN && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom()));
      end
      send_line();
   endtask

   initial begin
      logic [87:0] wrap_bodies[17];
      int          start_count;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed lines: one-byte line, extremes, extra bytes, duplicate, each frame fault.
      line_buf.delete();
      line_buf.push_back(8'hFF);
      send_line();
      make_frame('0);
      send_line();
      make_frame('1);
      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'hAA);
      send_line();
      make_frame('0);
      send_line();
      for (int f = 0; f < 4; f++) begin
         make_frame(fresh_body());
         case (f)
            0:       line_buf[0] = 8'h0F;
            1:       line_buf[1] = 8'd14;
            2:       line_buf[FRAME_LEN-1] = 8'hFF;
            default: line_buf[SUM_LAST+1] = line_buf[SUM_LAST+1] + 8'd1;
         endcase
         send_line();
      end
      make_frame(fresh_body());
      void'(line_buf.pop_back());
      send_line();
      drain_results();

      // History wrap: seventeen new frames, then the overwritten first one and a live one.
      for (int w = 0; w < 17; w++) begin
         wrap_bodies[w] = {$urandom(), $urandom(), 24'($urandom())};
         make_frame(wrap_bodies[w]);
         send_line();
      end
      make_frame(wrap_bodies[0]);
      send_line();
      make_frame(wrap_bodies[5]);
      send_line();
      drain_results();

      // Random lines, with one long receiver stall and occasional full drains.
      start_count = bytes_sent;
      while (bytes_sent - start_count < 850) begin
         random_line();
         if (!hold_request && bytes_sent - start_count > 400) hold_request <= 1'b1;
         if ($urandom_range(0, 29) == 0) drain_results();
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sensor_frame_checker_dedup.f
hdl/sfcd_pkg.sv
hdl/sfcd_ram.sv
hdl/sfcd_dp.sv
hdl/sfcd_ctrl.sv
hdl/sensor_frame_checker_dedup.sv
tb/testbench.sv
